/* rtl/dcp_pkg.sv */
// Shared types and constants for the drive command parser.
package dcp_pkg;

    // Characters the grammar looks for
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] LEN_DRIVE = 3'd5;
    localparam logic [2:0] LEN_LEFT  = 3'd4;
    localparam logic [2:0] LEN_RIGHT = 3'd5;

    typedef enum logic [12:0] {
        PH_OPEN      = 13'b0000000000001,
        PH_DQ_OPEN   = 13'b0000000000010,
        PH_DNAME     = 13'b0000000000100,
        PH_DQ_CLOSE  = 13'b0000000001000,
        PH_DCOLON    = 13'b0000000010000,
        PH_INNER     = 13'b0000000100000,
        PH_KQ_OPEN   = 13'b0000001000000,
        PH_KNAME     = 13'b0000010000000,
        PH_KCOLON    = 13'b0000100000000,
        PH_VAL_START = 13'b0001000000000,
        PH_DIGITS    = 13'b0010000000000,
        PH_AFTER     = 13'b0100000000000,
        PH_DONE      = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic               fail;
        t_phase             phase;
        logic [2:0]         key_pos;
        logic [1:0]         cands;
        logic [15:0]        acc;
        logic               neg;
        logic               cur_key;
        logic [15:0]        left_val;
        logic [15:0]        right_val;
        logic               seen_left;
        logic               seen_right;
    } t_state;

    localparam t_state STATE_RESET = '{
        fail: 1'b0, phase: PH_OPEN, key_pos: 3'd0, cands: 2'd0, acc: 16'd0,
        neg: 1'b0, cur_key: 1'b0, left_val: 16'd0, right_val: 16'd0,
        seen_left: 1'b0, seen_right: 1'b0
    };

    typedef struct packed {
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
        logic               accepted;
    } t_result;

endpackage

/* rtl/dcp_parser.sv */
// Parser state and the per-byte next-state logic.
module dcp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output dcp_pkg::t_result  o_result
);

    dcp_pkg::t_state r_state;
    dcp_pkg::t_state n_state;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == dcp_pkg::CH_SPACE) || (c == dcp_pkg::CH_TAB) ||
               (c == dcp_pkg::CH_CR) || (c == dcp_pkg::CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= dcp_pkg::CH_ZERO) && (c <= dcp_pkg::CH_NINE);
    endfunction

    function automatic logic [7:0] drive_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h64;
            3'd1:    return 8'h72;
            3'd2:    return 8'h69;
            3'd3:    return 8'h76;
            default: return 8'h65;
        endcase
    endfunction

    function automatic logic [7:0] left_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h6C;
            3'd1:    return 8'h65;
            3'd2:    return 8'h66;
            default: return 8'h74;
        endcase
    endfunction

    function automatic logic [7:0] right_char(input logic [2:0] p);
        case (p)
            3'd0:    return 8'h72;
            3'd1:    return 8'h69;
            3'd2:    return 8'h67;
            3'd3:    return 8'h68;
            default: return 8'h74;
        endcase
    endfunction

    // Commit the value under the current key and move past it
    function automatic dcp_pkg::t_state store_value(input dcp_pkg::t_state s);
        dcp_pkg::t_state t;
        logic [15:0]     v;
        t = s;
        v = s.neg ? (~s.acc + 16'd1) : s.acc;
        if (s.cur_key) begin
            t.right_val  = v;
            t.seen_right = 1'b1;
        end else begin
            t.left_val  = v;
            t.seen_left = 1'b1;
        end
        t.phase = dcp_pkg::PH_AFTER;
        return t;
    endfunction

    function automatic dcp_pkg::t_state after_value(input dcp_pkg::t_state s,
                                                   input logic [7:0] c);
        dcp_pkg::t_state t;
        t = s;
        if (!is_blank(c)) begin
            t.phase = (c == dcp_pkg::CH_COMMA) ? dcp_pkg::PH_KQ_OPEN : dcp_pkg::PH_DONE;
        end
        return t;
    endfunction

    function automatic dcp_pkg::t_state take_byte(input dcp_pkg::t_state s,
                                                 input logic [7:0] c);
        dcp_pkg::t_state t;
        logic [1:0]      keep;
        logic [15:0]     acc10;
        t     = s;
        keep  = 2'd0;
        acc10 = {s.acc[12:0], 3'b000} + {s.acc[14:0], 1'b0};
        if (!s.fail) begin
            unique case (s.phase)
                dcp_pkg::PH_OPEN: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_LBRACE) t.phase = dcp_pkg::PH_DQ_OPEN;
                        else                         t.fail = 1'b1;
                    end
                end
                dcp_pkg::PH_DQ_OPEN: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_QUOTE) t.phase = dcp_pkg::PH_DNAME;
                        else                        t.fail = 1'b1;
                        t.key_pos = 3'd0;
                    end
                end
                dcp_pkg::PH_DNAME: begin
                    if (s.key_pos < dcp_pkg::LEN_DRIVE && drive_char(s.key_pos) == c) begin
                        t.key_pos = s.key_pos + 3'd1;
                        if (t.key_pos == dcp_pkg::LEN_DRIVE) t.phase = dcp_pkg::PH_DQ_CLOSE;
                    end else begin
                        t.fail = 1'b1;
                    end
                end
                dcp_pkg::PH_DQ_CLOSE: begin
                    if (c == dcp_pkg::CH_QUOTE) t.phase = dcp_pkg::PH_DCOLON;
                    else                        t.fail = 1'b1;
                end
                dcp_pkg::PH_DCOLON: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_COLON) t.phase = dcp_pkg::PH_INNER;
                        else                        t.fail = 1'b1;
                    end
                end
                dcp_pkg::PH_INNER: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_LBRACE) t.phase = dcp_pkg::PH_KQ_OPEN;
                        else                         t.fail = 1'b1;
                    end
                end
                dcp_pkg::PH_KQ_OPEN: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_QUOTE) t.phase = dcp_pkg::PH_KNAME;
                        else                        t.fail = 1'b1;
                        t.key_pos = 3'd0;
                        t.cands   = 2'b11;
                    end
                end
                dcp_pkg::PH_KNAME: begin
                    if (c == dcp_pkg::CH_QUOTE) begin
                        if (s.cands[0] && s.key_pos == dcp_pkg::LEN_LEFT) begin
                            t.cur_key = 1'b0;
                            t.phase   = dcp_pkg::PH_KCOLON;
                        end else if (s.cands[1] && s.key_pos == dcp_pkg::LEN_RIGHT) begin
                            t.cur_key = 1'b1;
                            t.phase   = dcp_pkg::PH_KCOLON;
                        end else begin
                            t.fail = 1'b1;
                        end
                    end else begin
                        keep[0] = s.cands[0] && (s.key_pos < dcp_pkg::LEN_LEFT) &&
                                  (left_char(s.key_pos) == c);
                        keep[1] = s.cands[1] && (s.key_pos < dcp_pkg::LEN_RIGHT) &&
                                  (right_char(s.key_pos) == c);
                        t.cands = keep;
                        if (keep == 2'd0) t.fail = 1'b1;
                        else              t.key_pos = s.key_pos + 3'd1;
                    end
                end
                dcp_pkg::PH_KCOLON: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_COLON) t.phase = dcp_pkg::PH_VAL_START;
                        else                        t.fail = 1'b1;
                        t.acc = 16'd0;
                        t.neg = 1'b0;
                    end
                end
                dcp_pkg::PH_VAL_START: begin
                    if (!is_blank(c)) begin
                        if (c == dcp_pkg::CH_MINUS) begin
                            t.neg   = 1'b1;
                            t.phase = dcp_pkg::PH_DIGITS;
                        end else if (is_digit(c)) begin
                            t.acc   = {12'd0, c[3:0]};
                            t.phase = dcp_pkg::PH_DIGITS;
                        end else begin
                            t = after_value(store_value(s), c);
                        end
                    end
                end
                dcp_pkg::PH_DIGITS: begin
                    if (is_digit(c)) t.acc = acc10 + {12'd0, c[3:0]};
                    else             t = after_value(store_value(s), c);
                end
                dcp_pkg::PH_AFTER: begin
                    t = after_value(s, c);
                end
                dcp_pkg::PH_DONE: begin
                    t = s;
                end
                default: begin
                    t.fail = 1'b1;
                end
            endcase
        end
        return t;
    endfunction

    dcp_pkg::t_state s_upd;
    dcp_pkg::t_state s_fin;
    logic            ok;

    always_comb begin
        s_upd = take_byte(r_state, i_byte);
        s_fin = s_upd;
        if (!s_upd.fail && s_upd.phase == dcp_pkg::PH_DIGITS) s_fin = store_value(s_upd);
        ok = !s_fin.fail && (s_fin.phase == dcp_pkg::PH_AFTER ||
                             s_fin.phase == dcp_pkg::PH_DONE) &&
             s_fin.seen_left && s_fin.seen_right;
        o_result.left_speed  = ok ? s_fin.left_val : 16'sd0;
        o_result.right_speed = ok ? s_fin.right_val : 16'sd0;
        o_result.accepted    = ok;
        n_state = i_last ? dcp_pkg::STATE_RESET : s_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcp_pkg::STATE_RESET;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/drive_command_parser.sv */
// Top level of the drive command parser: stream ports, input and result registers.
// Streaming parser for the text command {"drive": {"left": N, "right": N}}. Send the
// message one character per request on the slave side, with tlast on its final
// character; exactly one result comes out per message, after that final character.
// The result carries both signed 16-bit values and an accepted flag; a rejected
// message gives accepted = 0 with both values zero. Values are decimal with an
// optional leading minus and wrap modulo 2^16. Characters after the parse finishes
// are ignored until tlast. Throughput is one character per clock cycle unless a final
// character is stalled: the only loop is the parser state update, which takes one
// pass of short logic (a compare per phase and a times-ten add) between the input
// register and the state and result registers. A result waiting on the master side
// stalls only a later final character; ordinary characters keep flowing underneath
// it. The final character goes through the input register, then the result register.
module drive_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] left_speed, [31:16] right_speed
    output logic        m_axis_tuser    // accepted
);

    // Input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Result register
    logic             r_out_vld;
    dcp_pkg::t_result r_out;
    dcp_pkg::t_result w_result;

    logic w_step;
    logic w_load;

    // Advance the held character unless it is a final one and the result slot is full and not being taken
    assign w_step        = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign w_load        = w_step && r_in_last;
    assign s_axis_tready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    dcp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    // Hold the result until taken; a new final character refills it in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.right_speed, r_out.left_speed};
    assign m_axis_tuser  = r_out.accepted;

`ifndef SYNTHESIS
    // A rejected command never carries values
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("rejected result carries nonzero values");

    // A final character must wait while an untaken result occupies the slot
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_in_last && r_out_vld && !m_axis_tready |=> r_in_vld && r_in_last)
        else $error("final character lost under a stalled result");

    // A new result appears only after a final character was processed
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld && r_in_last))
        else $error("result produced without a final character");
`endif

endmodule
